// ===== hw/rtl/nii_pkg.sv =====
// Package: payload types, status codes, sequencer states, sizing constants and Q32.32 helpers.
package nii_pkg;

  localparam int unsigned MaxPointsDef = 16;

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StEmpty = 3'd1,
    StFull  = 3'd2,
    StDup   = 3'd3,
    StSat   = 3'd4
  } status_e;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] abscissa;
    logic signed [31:0] ordinate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [4:0]         point_count;
  } out_item_t;

  typedef enum logic [3:0] {
    SIdle,
    SDupRd,
    SDupCmp,
    SHornRd,
    SHornLd,
    SHornMul,
    SHornAdd,
    SProdRd,
    SProdMul,
    SNumer,
    SDiv,
    SDivRnd,
    SStore,
    SFinish,
    SOut
  } state_e;

  // Rounded, saturating Q32.32 product from the 128-bit magnitude product.
  function automatic logic [64:0] q_mul_fix(input logic neg, input logic [127:0] p);
    logic [127:0] r;
    logic [63:0]  m;
    logic         s;
    r = p + 128'h8000_0000;
    s = 1'b0;
    m = 64'd0;
    if (r[127:96] != 32'd0) begin
      s = 1'b1;
      m = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (!neg) begin
      if (r[95]) begin
        s = 1'b1;
        m = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        m = r[95:32];
      end
    end else begin
      if (r[95] && r[94:32] != 63'd0) s = 1'b1;
      m = r[95] ? 64'h8000_0000_0000_0000 : (64'd0 - r[95:32]);
    end
    return {s, m};
  endfunction

  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63])
      return {1'b1, t[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
    return {1'b0, t[63:0]};
  endfunction

endpackage

// ===== hw/rtl/nii_mul.sv =====
// Shared 64x64 magnitude multiplier: one 32x32 unit summing four partial products in turn.
module nii_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  logic [2:0]   cnt_q, cnt_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    begin op_a = a_i[31:0];  op_b = b_i[31:0];  end
      2'd1:    begin op_a = a_i[31:0];  op_b = b_i[63:32]; end
      2'd2:    begin op_a = a_i[63:32]; op_b = b_i[31:0];  end
      default: begin op_a = a_i[63:32]; op_b = b_i[63:32]; end
    endcase
  end

  assign pp = 64'(op_a) * 64'(op_b);

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    if (start_i) begin
      cnt_d = 3'd0;
      acc_d = '0;
    end else if (!cnt_q[2]) begin
      unique case (cnt_q[1:0])
        2'd0:    acc_d = acc_q + 128'(pp);
        2'd1,
        2'd2:    acc_d = acc_q + (128'(pp) << 32);
        default: acc_d = acc_q + (128'(pp) << 64);
      endcase
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd4;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = cnt_q[2] && !start_i;
  assign p_o    = acc_q;
endmodule

// ===== hw/rtl/nii_div.sv =====
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
module nii_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [127:0] quo_o,
  output logic [64:0]  rem_o
);
  logic [7:0]   cnt_q;
  logic [127:0] quo_q;
  logic [64:0]  rem_q;
  logic [63:0]  den_q;
  logic [64:0]  sh;

  assign sh = {rem_q[63:0], quo_q[127]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 8'd128;
    end else if (start_i) begin
      cnt_q <= 8'd0;
    end else if (!cnt_q[7]) begin
      cnt_q <= cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // dividend is the numerator scaled by 2^32
      quo_q <= {32'd0, num_i, 32'd0};
      rem_q <= '0;
      den_q <= den_i;
    end else if (!cnt_q[7]) begin
      if (sh >= {1'b0, den_q}) begin
        rem_q <= sh - {1'b0, den_q};
        quo_q <= {quo_q[126:0], 1'b1};
      end else begin
        rem_q <= sh;
        quo_q <= {quo_q[126:0], 1'b0};
      end
    end
  end

  assign done_o = cnt_q[7] && !start_i;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== hw/rtl/newton_incremental_interpolator.sv =====
// Top level: sequencer, point stores, the shared multiply unit and the divide unit.
// The block takes no new word until the result of the last one has been taken.
// Each Horner step of an evaluate is a read, a pass through the shared 64x64
// multiplier and an add; an add scans the stored points for a duplicate, runs
// Horner, forms the difference product, then divides bit-serially and rounds.
// The result sits in an output register until taken.
module newton_incremental_interpolator #(
  parameter int unsigned MAX_POINTS = nii_pkg::MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nii_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nii_pkg::out_item_t out_data_o
);
  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  nii_pkg::state_e state_q, state_d;

  logic signed [31:0] xs_mem [MAX_POINTS];
  logic signed [63:0] cs_mem [MAX_POINTS];
  logic signed [31:0] xs_rd_q;
  logic signed [63:0] cs_rd_q;
  logic [IW-1:0]      rd_addr;
  logic               mem_we;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               kind_q;
  logic signed [31:0] x_q, y_q;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] num_q, num_d;
  logic               sat_q, sat_d;
  logic               dup_q, dup_d;
  logic               neg_q, neg_d;
  nii_pkg::out_item_t res_q, res_d;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b;
  logic [127:0] mul_p;
  logic        div_start, div_done;
  logic [127:0] div_quo;
  logic [64:0] div_rem;

  logic signed [63:0] diff;
  logic [64:0]        mres, ares;
  logic [63:0]        dmag, nmag, qmag;
  logic               top_idx;

  assign diff = 64'(signed'({x_q[31], x_q} - {xs_rd_q[31], xs_rd_q})) <<< 16;
  assign dmag = prod_q[63] ? 64'd0 - prod_q : prod_q;
  assign nmag = num_q[63] ? 64'd0 - num_q : num_q;
  assign mres = nii_pkg::q_mul_fix(neg_q, mul_p);
  assign ares = nii_pkg::sat_add(mres[63:0], cs_rd_q);
  assign top_idx = (idx_q == cnt_q - CW'(1));

  nii_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  nii_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(nmag), .den_i(dmag),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // store reads: index register picks the entry
  assign rd_addr = idx_q[IW-1:0];
  assign mem_we  = (state_q == nii_pkg::SStore);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      xs_mem[cnt_q[IW-1:0]] <= x_q;
      cs_mem[cnt_q[IW-1:0]] <= acc_q;
    end
    xs_rd_q <= xs_mem[rd_addr];
    cs_rd_q <= cs_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nii_pkg::SIdle: begin
        if (in_valid_i) begin
          if (in_data_i.kind) begin
            state_d = (cnt_q == '0) ? nii_pkg::SOut : nii_pkg::SHornRd;
          end else if (cnt_q >= CW'(MAX_POINTS)) begin
            state_d = nii_pkg::SOut;
          end else if (cnt_q == '0) begin
            state_d = nii_pkg::SStore;
          end else begin
            state_d = nii_pkg::SDupRd;
          end
        end
      end
      nii_pkg::SDupRd:  state_d = nii_pkg::SDupCmp;
      nii_pkg::SDupCmp: begin
        if (xs_rd_q == x_q) state_d = nii_pkg::SOut;
        else if (idx_q == '0) state_d = nii_pkg::SHornRd;
        else state_d = nii_pkg::SDupRd;
      end
      nii_pkg::SHornRd:  state_d = top_idx ? nii_pkg::SHornLd : nii_pkg::SHornMul;
      nii_pkg::SHornLd:  state_d = (idx_q == '0) ? nii_pkg::SFinish : nii_pkg::SHornRd;
      nii_pkg::SHornMul: if (mul_done) state_d = nii_pkg::SHornAdd;
      nii_pkg::SHornAdd: state_d = (idx_q == '0) ? nii_pkg::SFinish : nii_pkg::SHornRd;
      nii_pkg::SFinish:  state_d = kind_q ? nii_pkg::SOut : nii_pkg::SProdRd;
      nii_pkg::SProdRd:  state_d = nii_pkg::SProdMul;
      nii_pkg::SProdMul: begin
        if (mul_done) state_d = top_idx ? nii_pkg::SNumer : nii_pkg::SProdRd;
      end
      nii_pkg::SNumer:   state_d = (prod_q == '0) ? nii_pkg::SStore : nii_pkg::SDiv;
      nii_pkg::SDiv:     if (div_done) state_d = nii_pkg::SDivRnd;
      nii_pkg::SDivRnd:  state_d = nii_pkg::SStore;
      nii_pkg::SStore:   state_d = nii_pkg::SOut;
      nii_pkg::SOut:     if (out_ready_i) state_d = nii_pkg::SIdle;
      default:           state_d = nii_pkg::SIdle;
    endcase
  end

  always_comb begin
    logic signed [63:0] y64, npk;
    logic [64:0]        na, rq;
    logic [63:0]        q;
    logic               s;
    logic signed [63:0] m;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    num_d     = num_q;
    sat_d     = sat_q;
    dup_d     = dup_q;
    neg_d     = neg_q;
    res_d     = res_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    y64       = 64'(y_q) <<< 16;
    npk       = '0;
    na        = '0;
    rq        = '0;
    q         = '0;
    s         = 1'b0;
    m         = '0;
    unique case (state_q)
      nii_pkg::SIdle: begin
        sat_d = 1'b0;
        dup_d = 1'b0;
        idx_d = cnt_q - CW'(1);
        acc_d = 64'(in_data_i.ordinate) <<< 16;
      end
      nii_pkg::SDupRd: ;
      nii_pkg::SDupCmp: begin
        if (xs_rd_q == x_q) dup_d = 1'b1;
        else if (idx_q != '0) idx_d = idx_q - CW'(1);
        else idx_d = cnt_q - CW'(1);
      end
      nii_pkg::SHornRd: ;
      nii_pkg::SHornLd: begin
        // seed from the top coefficient
        acc_d = cs_rd_q;
        if (idx_q != '0) idx_d = idx_q - CW'(1);
      end
      nii_pkg::SHornMul: begin
        mul_a = diff[63] ? 64'd0 - diff : diff;
        mul_b = acc_q[63] ? 64'd0 - acc_q : acc_q;
        neg_d = diff[63] ^ acc_q[63];
      end
      nii_pkg::SHornAdd: begin
        acc_d = ares[63:0];
        sat_d = sat_q | mres[64] | ares[64];
        if (idx_q != '0) idx_d = idx_q - CW'(1);
      end
      nii_pkg::SFinish: begin
        idx_d  = '0;
        prod_d = 64'h1_0000_0000;
        if (kind_q) begin
          m = acc_q[63] ? 64'd0 - acc_q : acc_q;
          q = {16'd0, m[63:16]} + 64'(m[15]);
          if (!acc_q[63]) begin
            s = q > 64'h7FFF_FFFF;
            res_d.value = s ? 32'h7FFF_FFFF : q[31:0];
          end else begin
            s = q > 64'h8000_0000;
            res_d.value = s ? 32'h8000_0000 : 32'd0 - q[31:0];
          end
          res_d.status = (sat_q | s) ? nii_pkg::StSat : nii_pkg::StOk;
        end else begin
          npk   = (acc_q == 64'h8000_0000_0000_0000) ? 64'h7FFF_FFFF_FFFF_FFFF : -acc_q;
          na    = nii_pkg::sat_add(y64, npk);
          num_d = na[63:0];
          sat_d = sat_q | na[64] | (acc_q == 64'h8000_0000_0000_0000);
        end
      end
      nii_pkg::SProdRd: ;
      nii_pkg::SProdMul: begin
        mul_a = dmag;
        mul_b = diff[63] ? 64'd0 - diff : diff;
        neg_d = prod_q[63] ^ diff[63];
        if (mul_done) begin
          prod_d = mres[63:0];
          sat_d  = sat_q | mres[64];
          if (!top_idx) idx_d = idx_q + CW'(1);
        end
      end
      nii_pkg::SNumer: begin
        sat_d = sat_q | (prod_q == '0);
        acc_d = num_q[63] ? 64'h8000_0000_0000_0000
              : (num_q != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'd0;
        neg_d = num_q[63] ^ prod_q[63];
        div_start = 1'b1;
      end
      nii_pkg::SDiv: begin
        mul_a = nmag;
        mul_b = dmag;
      end
      nii_pkg::SDivRnd: begin
        rq = (div_rem >= (65'(dmag) - div_rem)) ? 65'd1 : 65'd0;
        q  = div_quo[63:0] + rq[63:0];
        s  = (div_quo[127:64] != '0) || (q == '0 && rq[0]);
        if (s) begin
          acc_d = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          sat_d = 1'b1;
        end else if (!neg_q) begin
          if (q[63]) begin
            acc_d = 64'h7FFF_FFFF_FFFF_FFFF;
            sat_d = 1'b1;
          end else begin
            acc_d = q;
          end
        end else begin
          if (q[63] && q[62:0] != '0) sat_d = 1'b1;
          acc_d = q[63] ? 64'h8000_0000_0000_0000 : 64'd0 - q;
        end
      end
      nii_pkg::SStore: begin
        cnt_d = cnt_q + CW'(1);
        res_d.value  = '0;
        res_d.status = sat_q ? nii_pkg::StSat : nii_pkg::StOk;
        res_d.point_count = 5'(cnt_q + CW'(1));
      end
      nii_pkg::SOut: ;
      default: ;
    endcase
    // start the shared multiplier from the read state that leads into a multiply state
    if ((state_q == nii_pkg::SHornRd && !top_idx) || state_q == nii_pkg::SProdRd)
      mul_start = 1'b1;
    // early exits
    if (state_q == nii_pkg::SIdle && in_valid_i) begin
      res_d.value = '0;
      res_d.point_count = 5'(cnt_q);
      if (in_data_i.kind) res_d.status = (cnt_q == '0) ? nii_pkg::StEmpty : nii_pkg::StOk;
      else res_d.status = (cnt_q >= CW'(MAX_POINTS)) ? nii_pkg::StFull : nii_pkg::StOk;
    end
    if (state_q == nii_pkg::SDupCmp && xs_rd_q == x_q) begin
      res_d.status = nii_pkg::StDup;
      res_d.value  = '0;
    end
    if (state_q == nii_pkg::SFinish && kind_q) res_d.point_count = 5'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nii_pkg::SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nii_pkg::SIdle && in_valid_i) begin
      kind_q <= in_data_i.kind;
      x_q    <= in_data_i.abscissa;
      y_q    <= in_data_i.ordinate;
    end
    acc_q  <= acc_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    sat_q  <= sat_d;
    dup_q  <= dup_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == nii_pkg::SIdle);
  assign out_valid_o = (state_q == nii_pkg::SOut);
  assign out_data_o  = res_q;
endmodule

// ===== hw/rtl/nii_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
module nii_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nii_pkg::out_item_t out_data_o
);
  // never take a word while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  // drop ready once a word is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");
  // a result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");
  // status within code range
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= nii_pkg::StSat) else $error("bad status");
  // error results carry zero value
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == nii_pkg::StEmpty
    || out_data_o.status == nii_pkg::StFull
    || out_data_o.status == nii_pkg::StDup) |-> out_data_o.value == 32'd0)
    else $error("error result with value");
endmodule

bind newton_incremental_interpolator nii_checker u_nii_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// ===== dv/tb_newton_incremental_interpolator.sv =====
// Testbench: self-checking stimulus and prediction for the Newton interpolator.
`timescale 1ns / 100ps

module tb_newton_incremental_interpolator;

  localparam int unsigned NPts      = nii_pkg::MaxPointsDef;
  localparam longint      Q32Max    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      Q32Min    = 64'sh8000_0000_0000_0000;
  localparam logic        KindAdd   = 1'b0;
  localparam logic        KindEval  = 1'b1;
  localparam int          RandItems = 520;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  nii_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  nii_pkg::out_item_t out_data_o;

  newton_incremental_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic signed [31:0] pt_x[NPts];
  longint             pt_coef[NPts];
  int unsigned        pt_count;

  nii_pkg::out_item_t result_q[$];
  int        n_errors;
  bit        idle_on;
  bit        stall_on;
  int        stall_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint from_mag(input bit neg, input logic [63:0] r, inout bit sat);
    if (!neg) begin
      if (r[63]) begin
        sat = 1'b1;
        return Q32Max;
      end
      return longint'(r);
    end
    if (r[63]) begin
      if (r[62:0] != 63'd0) sat = 1'b1;
      return Q32Min;
    end
    return -longint'(r);
  endfunction

  function automatic logic [63:0] mag(input longint a);
    return a < 0 ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, inout bit sat);
    logic [127:0] p;
    bit           neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, mag(a)} * {64'd0, mag(b)} + (128'd1 << 31);
    if (p[127:96] != 32'd0) begin
      sat = 1'b1;
      return neg ? Q32Min : Q32Max;
    end
    return from_mag(neg, p[95:32], sat);
  endfunction

  function automatic longint fx_div(input longint num, input longint den, inout bit sat);
    logic [127:0] dvd, q, rm;
    logic [63:0]  d;
    bit           neg;
    neg = (num < 0) != (den < 0);
    d   = mag(den);
    dvd = {32'd0, mag(num), 32'd0};
    q   = dvd / {64'd0, d};
    rm  = dvd % {64'd0, d};
    if (rm[63:0] >= d - rm[63:0]) q = q + 128'd1;
    if (q[127:64] != 64'd0) begin
      sat = 1'b1;
      return neg ? Q32Min : Q32Max;
    end
    return from_mag(neg, q[63:0], sat);
  endfunction

  function automatic longint fx_add(input longint a, input longint b, inout bit sat);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) begin
      sat = 1'b1;
      return t[64] ? Q32Min : Q32Max;
    end
    return t[63:0];
  endfunction

  // difference of two Q16.16 values widened to Q32.32
  function automatic longint wide_diff(input logic signed [31:0] x,
                                       input logic signed [31:0] a);
    return (longint'(x) - longint'(a)) * 65536;
  endfunction

  function automatic longint poly_at(input logic signed [31:0] x, inout bit sat);
    longint acc;
    acc = pt_coef[pt_count - 1];
    for (int i = int'(pt_count) - 2; i >= 0; i--)
      acc = fx_add(fx_mul(wide_diff(x, pt_x[i]), acc, sat), pt_coef[i], sat);
    return acc;
  endfunction

  function automatic logic signed [31:0] narrow_q16(input longint v, inout bit sat);
    logic [63:0] m;
    m = mag(v);
    m = (m >> 16) + ((m >> 15) & 64'd1);
    if (v >= 0) begin
      if (m > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      return m[31:0];
    end
    if (m > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return 32'd0 - m[31:0];
  endfunction

  // Apply one word to the predictor state and return the result it causes.
  function automatic nii_pkg::out_item_t interp_step(input nii_pkg::in_item_t it);
    nii_pkg::out_item_t r;
    bit        sat, dup;
    longint    pk, prod, numer, coef;
    sat = 1'b0;
    dup = 1'b0;
    r.value  = '0;
    r.status = nii_pkg::StOk;
    if (it.kind == KindAdd) begin
      for (int unsigned i = 0; i < pt_count; i++)
        if (pt_x[i] == it.abscissa) dup = 1'b1;
      if (pt_count >= NPts) begin
        r.status = nii_pkg::StFull;
      end else if (dup) begin
        r.status = nii_pkg::StDup;
      end else begin
        if (pt_count == 0) begin
          coef = longint'(it.ordinate) * 65536;
        end else begin
          pk   = poly_at(it.abscissa, sat);
          prod = 64'sd1 <<< 32;
          for (int unsigned i = 0; i < pt_count; i++)
            prod = fx_mul(prod, wide_diff(it.abscissa, pt_x[i]), sat);
          numer = fx_add(longint'(it.ordinate) * 65536, pk == Q32Min ? Q32Max : -pk, sat);
          if (pk == Q32Min) sat = 1'b1;
          if (prod == 0) begin
            sat  = 1'b1;
            coef = numer > 0 ? Q32Max : numer < 0 ? Q32Min : 64'sd0;
          end else begin
            coef = fx_div(numer, prod, sat);
          end
        end
        pt_x[pt_count]    = it.abscissa;
        pt_coef[pt_count] = coef;
        pt_count++;
        r.status = sat ? nii_pkg::StSat : nii_pkg::StOk;
      end
    end else if (pt_count == 0) begin
      r.status = nii_pkg::StEmpty;
    end else begin
      r.value  = narrow_q16(poly_at(it.abscissa, sat), sat);
      r.status = sat ? nii_pkg::StSat : nii_pkg::StOk;
    end
    r.point_count = 5'(pt_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(15, 80));
  endfunction

  task automatic send_word(input logic kind, input logic signed [31:0] x,
                           input logic signed [31:0] y);
    int                gap;
    nii_pkg::in_item_t it;
    gap = pick_gap();
    it.kind     = kind;
    it.abscissa = x;
    it.ordinate = y;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    result_q.insert(result_q.size(), interp_step(it));
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    nii_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected word", out_data_o.value, 0);
      end else begin
        want = result_q.pop_front();
        if (out_data_o.value !== want.value)
          report_mismatch("value", out_data_o.value, want.value);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.point_count !== want.point_count)
          report_mismatch("point_count", out_data_o.point_count, want.point_count);
      end
    end
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    int unsigned r;
    if (!rst_ni) begin
      stall_left = 0;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!stall_on) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) stall_left = int'($urandom_range(15, 80));
      else if (r < 30) stall_left = int'($urandom_range(0, 3));
      out_ready_i <= (r >= 30);
    end
  end

  function automatic logic signed [31:0] rand_q16();
    // mostly within +-64.0, sometimes anything
    if ($urandom_range(0, 4) == 0) return $urandom;
    return int'($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
  endfunction

  task automatic test_empty_eval();
    send_word(KindEval, 32'sh0, 32'sh7FFF_FFFF);
    send_word(KindEval, 32'sh8000_0000, 32'sh8000_0000);
  endtask

  // points one LSB apart make the product vanish; zero ordinates keep the numerator zero
  task automatic test_clustered_points();
    for (int i = 0; i < 4; i++) send_word(KindAdd, i, 32'sh0);
    send_word(KindEval, 32'sh3, 32'sh0);
    send_word(KindEval, 32'sh7FFF_FFFF, 32'sh0);
    send_word(KindEval, 32'sh8000_0000, 32'sh0);
  endtask

  task automatic test_duplicate();
    send_word(KindAdd, 32'sh2, 32'sh0001_0000);
    send_word(KindAdd, 32'sh0, 32'sh8000_0000);
  endtask

  task automatic test_extreme_points();
    send_word(KindAdd, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_word(KindAdd, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_word(KindEval, 32'sh0001_8000, 32'sh0);
    send_word(KindEval, 32'sh8000_0000, 32'sh0);
    send_word(KindEval, 32'sh7FFF_FFFF, 32'sh0);
  endtask

  task automatic test_random_mix();
    int          k;
    logic signed [31:0] x;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 60 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      // keep room for the vanishing-product and full-store tests
      if (pt_count < NPts - 2 && $urandom_range(0, 9) < 3) begin
        x = rand_q16();
        if ($urandom_range(0, 9) == 0) begin
          k = int'($urandom_range(0, pt_count - 1));
          x = pt_x[k];
        end
        if (x == 32'sh4) x = 32'sh5;
        send_word(KindAdd, x, rand_q16());
      end else begin
        send_word(KindEval, rand_q16(), $urandom);
      end
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // nonzero numerator over a product that rounds to zero
  task automatic test_vanishing_product();
    send_word(KindAdd, 32'sh4, 32'sh0001_0000);
    send_word(KindEval, 32'sh4, 32'sh0);
  endtask

  task automatic test_full_store();
    logic signed [31:0] x;
    while (pt_count < NPts) begin
      x = rand_q16();
      send_word(KindAdd, x, rand_q16());
    end
    send_word(KindAdd, 32'sh1234_5678, 32'sh0);
    send_word(KindEval, 32'sh0, 32'sh0);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    n_errors    = 0;
    pt_count    = 0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_eval();
    test_clustered_points();
    test_duplicate();
    test_extreme_points();
    test_random_mix();
    test_vanishing_product();
    test_full_store();

    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
